// ===== src/stks_pkg.sv =====
// Package for the streaming top-k magnitude selector.
// Types, field widths and rank-key helper; no dependencies.
`timescale 1ns / 1ps
package stks_pkg;

    localparam int SCORE_BITS = 17;
    localparam int KEY_BITS   = 17;
    localparam int KCFG_BITS  = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CUT,
        ST_SCAN,
        ST_SHIFT,
        ST_INSERT,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

    // Rank key: 0 when not available, else min(|score|, 65535) + 1.
    function automatic logic [KEY_BITS-1:0] rank_key(input logic [SCORE_BITS-1:0] raw,
                                                     input logic na);
        logic [SCORE_BITS-1:0] mag;
        begin
            mag = raw[SCORE_BITS-1] ? (~raw + 1'b1) : raw;
            if (na)
            begin
                rank_key = '0;
            end
            else if (mag[SCORE_BITS-1])
            begin
                rank_key = {1'b1, 16'h0000};
            end
            else
            begin
                rank_key = mag + 1'b1;
            end
        end
    endfunction

endpackage

// ===== src/stks_store.sv =====
// Entry store for the top-k selector: one synchronous memory with a registered read.
// Imports stks_pkg; field widths come from the WIDTH parameter.
`timescale 1ns / 1ps
module stks_store
    import stks_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 66
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/streaming_top_k_magnitude_selector_core.sv =====
// Top level of the streaming top-k magnitude selector.
// Uses stks_pkg and stks_store (entry memory).
`timescale 1ns / 1ps
//
// Channel   Dir  Handshake         Payload
// s_axis    in   tvalid/tready     tdata={score_na,score,item_index}, tlast=last_item
// m_axis    out  tvalid/tready     tdata={out_rank,out_na,out_score,out_index}, tlast
// cfg       in   cfg_we            cfg_wdata = keep_count
//
// One item at a time. An item steps through accept, trim, last read and write,
// with a read, then a compare and move down one slot, for each kept entry it
// passes on the way up, plus a compare when the scan stops on a better entry;
// at worst it passes MAX_KEEP entries, and the single memory port sets the pace.
// A last item then emits one result per kept entry.
// Reset clears the count, state and output valid and sets keep_count to 64; memory content is left undefined.
// The output register holds while m_axis_tready is low; the sequencer waits.
module streaming_top_k_magnitude_selector_core
    import stks_pkg::*;
#(
    parameter int MAX_KEEP   = 64,
    parameter int INDEX_BITS = 31
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // item_index[30:0], score[47:31], score_na[48]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_index[30:0], out_score[47:31], out_na[48], out_rank[54:49]
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);

    localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CW = $clog2(MAX_KEEP + 1) + 1;
    localparam int EW = KEY_BITS + SCORE_BITS + INDEX_BITS + 1;

    // entry layout: {na, index, score, key}
    logic [KCFG_BITS-1:0]  keep_reg;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         lim_reg, lim_next;
    state_t                state_reg, state_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [SCORE_BITS-1:0] sc_reg, sc_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic                  na_reg, na_next;
    logic                  last_reg, last_next;
    logic                  ov_reg, ov_next;
    logic [55:0]           od_reg, od_next;
    logic                  ol_reg, ol_next;

    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [EW-1:0]         wdata, rdata;
    logic [CW-1:0]         kclamp;

    stks_store #(.DEPTH(MAX_KEEP), .WIDTH(EW)) u_store
    (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    always_comb
    begin
        if (keep_reg == '0)
        begin
            kclamp = CW'(1);
        end
        else if (keep_reg > KCFG_BITS'(MAX_KEEP))
        begin
            kclamp = CW'(MAX_KEEP);
        end
        else
        begin
            kclamp = CW'(keep_reg);
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        lim_next   = lim_reg;
        key_next   = key_reg;
        sc_next    = sc_reg;
        idx_next   = idx_reg;
        na_next    = na_reg;
        last_next  = last_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        ol_next    = ol_reg;
        we         = 1'b0;
        waddr      = pos_reg[AW-1:0];
        wdata      = {na_reg, idx_reg, sc_reg, key_reg};
        raddr      = AW'(pos_reg - 1'b1);
        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    idx_next  = s_axis_tdata[INDEX_BITS-1:0];
                    na_next   = s_axis_tdata[48];
                    sc_next   = s_axis_tdata[48] ? '0 : s_axis_tdata[47:31];
                    key_next  = rank_key(s_axis_tdata[47:31], s_axis_tdata[48]);
                    last_next = s_axis_tlast;
                    state_next = ST_CUT;
                end
            end
            ST_CUT:
            begin
                // trim to limit, then read worst entry
                if (cnt_reg > kclamp)
                begin
                    cnt_next = kclamp;
                    pos_next = kclamp;
                end
                else
                begin
                    pos_next = cnt_reg;
                end
                lim_next   = kclamp;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // raddr = pos-1 presented; data arrives next cycle in ST_SHIFT
                if (pos_reg == '0)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (rdata[KEY_BITS-1:0] < key_reg)
                begin
                    // entry pos-1 moves to pos when room remains
                    if (pos_reg < lim_reg)
                    begin
                        we    = 1'b1;
                        wdata = rdata;
                    end
                    pos_next   = pos_reg - 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                if (pos_reg < lim_reg)
                begin
                    we = 1'b1;
                    cnt_next = (cnt_reg < lim_reg) ? cnt_reg + 1'b1 : cnt_reg;
                end
                pos_next   = '0;
                state_next = last_reg ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                raddr = pos_reg[AW-1:0];
                if (!ov_reg || m_axis_tready)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                od_next = {1'b0, 6'(pos_reg), rdata[EW-1], rdata[KEY_BITS +: SCORE_BITS],
                           31'(rdata[EW-2 -: INDEX_BITS])};
                ol_next = (pos_reg + 1'b1 == cnt_reg);
                ov_next = 1'b1;
                if (pos_reg + 1'b1 == cnt_reg)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            keep_reg  <= 7'd64;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                keep_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        lim_reg  <= lim_next;
        key_reg  <= key_next;
        sc_reg   <= sc_next;
        idx_reg  <= idx_next;
        na_reg   <= na_next;
        last_reg <= last_next;
        od_reg   <= od_next;
        ol_reg   <= ol_next;
    end

endmodule
